@@ design/assert_macros.svh @@
// Assertion macros included by the top-level design file; defining NO_ASSERTIONS removes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ design/stg_pkg.sv @@
// Shared constants, types and the quarter-wave sine table of the tone generator.
package stg_pkg;

    // Table geometry and block size limits.
    localparam int TABLE_ADDRESS_BITS = 10;
    localparam int TABLE_SIZE         = 1 << TABLE_ADDRESS_BITS;
    localparam int TABLE_W            = 15;
    localparam int MAX_BLOCK          = 64;
    localparam int CNT_W              = $clog2(MAX_BLOCK + 1);

    // Register widths and reset values.
    localparam int PHASE_W            = 32;
    localparam int GAIN_W             = 16;
    localparam int BLEN_W             = 7;
    localparam int SAMPLE_W           = 16;
    localparam int CFG_IDX_W          = 2;
    localparam int CFG_DATA_W         = 32;
    localparam logic [PHASE_W-1:0] PHASE_INC_RESET = 32'd89478485;
    localparam logic [GAIN_W-1:0]  GAIN_RESET      = 16'd32768;
    localparam logic [BLEN_W-1:0]  BLEN_RESET      = 7'd64;

    // Register indices on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLEN      = 2'd2;

    // Scaling arithmetic: product width, rounding constant and magnitude limit.
    localparam int PROD_W = TABLE_W + GAIN_W;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << 14);
    localparam logic [TABLE_W-1:0] MAG_MAX   = {TABLE_W{1'b1}};

    // Output queue depth.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // One result transaction.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } sample_t;

    typedef logic [TABLE_W-1:0] sine_table_t [TABLE_SIZE];

    // Builds the table from a Q30 Taylor series of the half-step offset angles.
    function automatic sine_table_t build_sine_table();
        sine_table_t t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        int          i;
        for (i = 0; i < TABLE_SIZE; i++)
        begin
            x    = (64'd1686629713 * 64'(2 * i + 1)) >> (TABLE_ADDRESS_BITS + 1);
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            term = ((term * x2) >> 30) / 64'd6;
            sum  = (sum > term) ? sum - term : 64'd0;
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 64'd42;
            sum  = (sum > term) ? sum - term : 64'd0;
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 64'd110;
            sum  = (sum > term) ? sum - term : 64'd0;
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + term;
            if (sum > 64'd1073741824)
            begin
                sum = 64'd1073741824;
            end
            v = (sum * 64'd32767 + 64'd536870912) >> 30;
            if (v > 64'd32767)
            begin
                v = 64'd32767;
            end
            t[i] = v[TABLE_W-1:0];
        end
        return t;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

@@ design/stg_sine_rom.sv @@
// Synchronous quarter-wave sine ROM with a registered read port.
module stg_sine_rom (
    input  logic                                 clk,
    input  logic [stg_pkg::TABLE_ADDRESS_BITS-1:0] addr,
    output logic [stg_pkg::TABLE_W-1:0]          data
);
    import stg_pkg::*;

    logic [TABLE_W-1:0] data_reg;

    // One read per cycle, data available the cycle after the address.
    always_ff @(posedge clk)
    begin
        data_reg <= SINE_TABLE[addr];
    end

    assign data = data_reg;

endmodule

@@ design/stg_out_fifo.sv @@
// Small output queue that decouples the sample pipeline from the result channel.
module stg_out_fifo (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  stg_pkg::sample_t                push_data,
    input  logic                            pop,
    output logic                            valid,
    output stg_pkg::sample_t                head,
    output logic [stg_pkg::FIFO_CNT_W-1:0]  count
);
    import stg_pkg::*;

    sample_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;

    // Storage is written on push; the head is always presented.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        count_next = count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

@@ design/sine_tone_generator_top.sv @@
// Top level of the sine tone generator: phase accumulator, sine ROM, scaler and output queue.
// A block request of N samples (N = block_length, at most 64) yields one sample per cycle
// while fewer than FIFO_DEPTH samples are outstanding; each passes the ROM read register and
// the product register into the output queue. The next request is taken in the cycle the
// last sample of the current block is issued to the ROM. Reset, and every gain write, start
// a zero-threshold binary search over the ROM during which requests are stalled.
`include "assert_macros.svh"

module sine_tone_generator_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [stg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [stg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               block_request,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [stg_pkg::SAMPLE_W-1:0] left_sample,
    output logic signed [stg_pkg::SAMPLE_W-1:0] right_sample,
    output logic                               last_in_block
);
    import stg_pkg::*;

    localparam int AW1   = TABLE_ADDRESS_BITS + 1;
    localparam int LEN_W = (BLEN_W > CNT_W) ? BLEN_W : CNT_W;
    localparam int MAG_W = PROD_W + 1 - 15;

    // Search state codes.
    localparam logic [1:0] SR_IDLE = 2'd0;
    localparam logic [1:0] SR_READ = 2'd1;
    localparam logic [1:0] SR_EVAL = 2'd2;

    // Configuration registers.
    logic [PHASE_W-1:0] inc_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [BLEN_W-1:0]  blen_reg;
    logic               wr_inc;
    logic               wr_gain;
    logic               wr_blen;

    // Generator state.
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [PHASE_W-1:0]    phase_reg;
    logic [PHASE_W-1:0]    phase_next;
    logic                  prev_neg_reg;
    logic                  prev_neg_next;
    logic [FIFO_CNT_W-1:0] pend_reg;
    logic [FIFO_CNT_W-1:0] pend_next;

    // Zero-threshold search.
    logic [1:0]     sr_state_reg;
    logic [1:0]     sr_state_next;
    logic [AW1-1:0] lo_reg;
    logic [AW1-1:0] lo_next;
    logic [AW1-1:0] hi_reg;
    logic [AW1-1:0] hi_next;
    logic [AW1-1:0] zthr_reg;
    logic [AW1-1:0] zthr_next;
    logic [AW1:0]   mid_sum;
    logic [TABLE_ADDRESS_BITS-1:0] mid;
    logic           search_busy;

    // Issue-stage signals.
    logic [1:0]                    quad;
    logic [TABLE_ADDRESS_BITS-1:0] k_raw;
    logic [TABLE_ADDRESS_BITS-1:0] k_idx;
    logic                          neg_issue;
    logic                          last_issue;
    logic                          issue;
    logic                          in_accept;
    logic                          start;
    logic [LEN_W-1:0]              len_ext;
    logic [CNT_W-1:0]              len_eff;

    // ROM and pipeline.
    logic [TABLE_ADDRESS_BITS-1:0] rom_addr;
    logic [TABLE_W-1:0]            rom_data;
    logic [PROD_W-1:0]             prod;
    logic                          v1_reg;
    logic                          neg1_reg;
    logic                          last1_reg;
    logic                          v2_reg;
    logic                          neg2_reg;
    logic                          last2_reg;
    logic [PROD_W-1:0]             prod2_reg;
    logic [PROD_W:0]               rounded;
    logic [MAG_W-1:0]              mag_full;
    logic [TABLE_W-1:0]            mag;
    sample_t                       push_data;
    sample_t                       head;
    logic                          pop;
    logic [FIFO_CNT_W-1:0]         fifo_count;

    // Configuration write decode.
    always_comb
    begin
        wr_inc  = 1'b0;
        wr_gain = 1'b0;
        wr_blen = 1'b0;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_PHASE_INC: wr_inc  = 1'b1;
                REG_GAIN:      wr_gain = 1'b1;
                REG_BLEN:      wr_blen = 1'b1;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_reg  <= PHASE_INC_RESET;
            gain_reg <= GAIN_RESET;
            blen_reg <= BLEN_RESET;
        end
        else
        begin
            if (wr_inc)
            begin
                inc_reg <= cfg_data[PHASE_W-1:0];
            end
            if (wr_gain)
            begin
                gain_reg <= cfg_data[GAIN_W-1:0];
            end
            if (wr_blen)
            begin
                blen_reg <= cfg_data[BLEN_W-1:0];
            end
        end
    end

    // Effective block length, limited to the largest block.
    always_comb
    begin
        len_ext = LEN_W'(blen_reg);
        if (len_ext > LEN_W'(MAX_BLOCK))
        begin
            len_eff = CNT_W'(MAX_BLOCK);
        end
        else
        begin
            len_eff = CNT_W'(len_ext);
        end
    end

    // Quadrant decode and mirrored table index of the current phase.
    // Samples at mirrored indices below the zero threshold scale to zero and count as
    // non-negative, which is what the restart rule needs.
    always_comb
    begin
        quad       = phase_reg[PHASE_W-1 -: 2];
        k_raw      = phase_reg[PHASE_W-3 -: TABLE_ADDRESS_BITS];
        k_idx      = quad[0] ? ~k_raw : k_raw;
        neg_issue  = quad[1] && ({1'b0, k_idx} >= zthr_reg);
        last_issue = (cnt_reg == CNT_W'(1));
    end

    assign search_busy = (sr_state_reg != SR_IDLE);
    assign issue       = (cnt_reg != '0) && (pend_reg < FIFO_CNT_W'(FIFO_DEPTH));
    assign in_stall    = search_busy || ((cnt_reg != '0) && !(issue && last_issue));
    assign in_accept   = in_valid && !in_stall;
    assign start       = in_accept && block_request && (len_eff != '0);
    assign pop         = out_valid && !out_stall;

    // Sample counter, phase accumulator and outstanding-transaction count.
    always_comb
    begin
        cnt_next      = cnt_reg;
        phase_next    = phase_reg;
        prev_neg_next = prev_neg_reg;
        if (start)
        begin
            cnt_next = len_eff;
        end
        else if (issue)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
        if (wr_inc)
        begin
            phase_next = '0;
        end
        else if (issue)
        begin
            if (prev_neg_reg && !neg_issue)
            begin
                phase_next = inc_reg;
            end
            else
            begin
                phase_next = phase_reg + inc_reg;
            end
        end
        if (issue)
        begin
            prev_neg_next = neg_issue;
        end
        pend_next = pend_reg + FIFO_CNT_W'(issue) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            phase_reg    <= '0;
            prev_neg_reg <= 1'b0;
            pend_reg     <= '0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            phase_reg    <= phase_next;
            prev_neg_reg <= prev_neg_next;
            pend_reg     <= pend_next;
        end
    end

    // Binary search for the first table index whose scaled value is not zero.
    always_comb
    begin
        mid_sum       = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid           = mid_sum[AW1-1:1];
        sr_state_next = sr_state_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        zthr_next     = zthr_reg;
        unique case (sr_state_reg)
            SR_IDLE:
            begin
                sr_state_next = SR_IDLE;
            end
            SR_READ:
            begin
                if (lo_reg >= hi_reg)
                begin
                    zthr_next     = lo_reg;
                    sr_state_next = SR_IDLE;
                end
                else
                begin
                    sr_state_next = SR_EVAL;
                end
            end
            SR_EVAL:
            begin
                if (prod >= ROUND_HALF)
                begin
                    hi_next = {1'b0, mid};
                end
                else
                begin
                    lo_next = {1'b0, mid} + 1'b1;
                end
                sr_state_next = SR_READ;
            end
            default:
            begin
                sr_state_next = SR_IDLE;
            end
        endcase
        if (wr_gain)
        begin
            sr_state_next = SR_READ;
            lo_next       = '0;
            hi_next       = AW1'(TABLE_SIZE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sr_state_reg <= SR_READ;
            lo_reg       <= '0;
            hi_reg       <= AW1'(TABLE_SIZE);
            zthr_reg     <= AW1'(TABLE_SIZE);
        end
        else
        begin
            sr_state_reg <= sr_state_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            zthr_reg     <= zthr_next;
        end
    end

    // The ROM port serves the search while it runs and the sample stream otherwise.
    assign rom_addr = search_busy ? mid : k_idx;

    stg_sine_rom u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    assign prod = PROD_W'(rom_data) * PROD_W'(gain_reg);

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
        end
    end

    // Pipeline payload: sign and last flag follow the table word, then the product.
    always_ff @(posedge clk)
    begin
        neg1_reg  <= quad[1];
        last1_reg <= last_issue;
        neg2_reg  <= neg1_reg;
        last2_reg <= last1_reg;
        prod2_reg <= prod;
    end

    // Rounding, saturation and sign of the scaled sample.
    always_comb
    begin
        rounded  = {1'b0, prod2_reg} + {1'b0, ROUND_HALF};
        mag_full = rounded[PROD_W:15];
        if (mag_full > MAG_W'(MAG_MAX))
        begin
            mag = MAG_MAX;
        end
        else
        begin
            mag = mag_full[TABLE_W-1:0];
        end
        if (neg2_reg && (mag != '0))
        begin
            push_data.sample = -$signed({1'b0, mag});
        end
        else
        begin
            push_data.sample = $signed({1'b0, mag});
        end
        push_data.last = last2_reg;
    end

    stg_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (v2_reg),
        .push_data (push_data),
        .pop       (pop),
        .valid     (out_valid),
        .head      (head),
        .count     (fifo_count)
    );

    assign left_sample   = head.sample;
    assign right_sample  = head.sample;
    assign last_in_block = head.last;

    // Checks on the credit accounting and the block counter.
    `ASSERT_ALWAYS(a_pend_bound, pend_reg <= FIFO_CNT_W'(FIFO_DEPTH), "outstanding samples exceed queue depth")
    `ASSERT_ALWAYS(a_pend_track, pend_reg == fifo_count + FIFO_CNT_W'(v1_reg) + FIFO_CNT_W'(v2_reg), "credit count disagrees with pipeline contents")
    `ASSERT_NEXT(a_start_loads, start, cnt_reg != '0, "accepted block request did not load the sample counter")

endmodule
